FILE: rtl/lpht_pkg.sv
`timescale 1ns / 1ps
package lpht_pkg;
    localparam int TableEntriesDef = 256;
    localparam int MaxKeyBytesDef = 256;
    localparam logic [63:0] HASH_BASIS = 64'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;
    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_FOUND = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_BAD_LEN = 3'd4;
    localparam logic [1:0] FUNC_INSERT = 2'd0;
endpackage

FILE: rtl/lpht_ram.sv
`timescale 1ns / 1ps
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

FILE: rtl/lpht_mod.sv
`timescale 1ns / 1ps
// restoring remainder of a 64-bit value by a 17-bit divisor, one bit a cycle
module lpht_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [16:0] o_rem
);
    logic [63:0] r_num;
    logic [17:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] w_sh;
    always_comb begin
        w_sh = {r_rem[16:0], r_num[63]};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_rem  <= '0;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_num <= {r_num[62:0], 1'b0};
                r_rem <= (w_sh >= {1'b0, i_den}) ? w_sh - {1'b0, i_den} : w_sh;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_rem  = r_rem[16:0];
endmodule

FILE: rtl/linear_probe_hash_table_core.sv
`timescale 1ns / 1ps
// Non-final key byte: accepted in idle, hashed (multiply and fold) in S_MUL, then idle again;
// o_stall is high meanwhile. Final byte: fold, then 64-step remainder unit to the start slot;
// per probed slot, read stored length and occupancy, then compare stored key bytes in turn;
// insert copies the key bytes, then writes length and stamp; the result is then registered.
// Reset (synchronous, active low) empties the table at once via occupancy flags,
// clears the key state and sets the slot count register to 256.
module linear_probe_hash_table_core
    import lpht_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDef,
    parameter int MAX_KEY_BYTES = MaxKeyBytesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [7:0]  i_key_byte,
    input  logic        i_key_last,
    input  logic [63:0] i_stamp_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [63:0] o_stamp_out,
    output logic [7:0]  o_slot_index
);
    localparam int SW = $clog2(TABLE_ENTRIES);
    localparam int KW = $clog2(MAX_KEY_BYTES);
    localparam int LW = KW + 1;
    localparam int BW = SW + KW;

    localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_MOD = 4'd2,
        S_RD = 4'd3, S_CHK = 4'd4, S_CMP = 4'd5, S_CMPW = 4'd6,
        S_WR = 4'd7, S_OUT = 4'd8, S_STW = 4'd9;

    logic [3:0]    r_state;
    logic [8:0]    r_size_reg;
    logic [63:0]   r_hash;
    logic [LW-1:0] r_len;
    logic          r_ovf;
    logic          r_func;
    logic [63:0]   r_stamp;
    logic [7:0]    r_byte;
    logic          r_last;
    logic [TABLE_ENTRIES-1:0] r_occ;
    logic [SW-1:0] r_slot;
    logic [16:0]   r_cnt;
    logic [LW-1:0] r_bi;
    logic          r_ovld;
    logic [2:0]    r_ost;
    logic [63:0]   r_ostamp;
    logic [7:0]    r_oidx;
    logic [2:0]    r_out_st;
    logic [63:0]   r_out_stamp;
    logic [7:0]    r_out_idx;

    logic [16:0] w_size;
    logic [63:0] w_prod;
    logic        w_mdone;
    logic [16:0] w_rem;
    logic        w_acc;
    logic        w_load;

    // key buffer
    logic          kb_we;
    logic [KW-1:0] kb_wa, kb_ra;
    logic [7:0]    kb_rd;
    // slot store
    logic          sb_we;
    logic [BW-1:0] sb_wa, sb_ra;
    logic [7:0]    sb_rd;
    logic          sl_we;
    logic [LW-1:0] sl_rd;
    logic          ss_we;
    logic [63:0]   ss_rd;

    always_comb begin
        if (r_size_reg == 9'd0) begin
            w_size = 17'd1;
        end else if ({8'd0, r_size_reg} > 17'(TABLE_ENTRIES)) begin
            w_size = 17'(TABLE_ENTRIES);
        end else begin
            w_size = {8'd0, r_size_reg};
        end
    end

    // prime 16777619 = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 2^0
    assign w_prod = (r_hash << 24) + (r_hash << 8) + (r_hash << 7) +
                    (r_hash << 4) + (r_hash << 1) + r_hash;
    assign w_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign w_load = (r_state == S_OUT) && (!r_ovld || !i_stall);
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {23'd0, r_size_reg} : 32'd0;

    lpht_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == S_MUL && r_last),
        .i_num(w_prod ^ {56'd0, r_byte}), .i_den(w_size),
        .o_done(w_mdone), .o_rem(w_rem)
    );

    assign kb_we = (r_state == S_MUL) && !r_len[KW];
    assign kb_wa = r_len[KW-1:0];
    assign kb_ra = r_bi[KW-1:0];
    lpht_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_kbuf (
        .i_clk(i_clk), .i_we(kb_we), .i_waddr(kb_wa), .i_wdata(r_byte),
        .i_raddr(kb_ra), .o_rdata(kb_rd)
    );

    assign sb_we = (r_state == S_WR) && (r_bi != '0);
    assign sb_wa = {r_slot, KW'(r_bi - LW'(1))};
    assign sb_ra = {r_slot, r_bi[KW-1:0]};
    lpht_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * MAX_KEY_BYTES)) u_sbytes (
        .i_clk(i_clk), .i_we(sb_we), .i_waddr(sb_wa), .i_wdata(kb_rd),
        .i_raddr(sb_ra), .o_rdata(sb_rd)
    );

    assign sl_we = (r_state == S_STW);
    lpht_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES)) u_slen (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(r_slot), .i_wdata(r_len),
        .i_raddr(r_slot), .o_rdata(sl_rd)
    );
    assign ss_we = sl_we;
    lpht_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_sstamp (
        .i_clk(i_clk), .i_we(ss_we), .i_waddr(r_slot), .i_wdata(r_stamp),
        .i_raddr(r_slot), .o_rdata(ss_rd)
    );

    logic [SW-1:0] w_next;
    always_comb begin
        if ({{(17-SW){1'b0}}, r_slot} + 17'd1 >= w_size) begin
            w_next = '0;
        end else begin
            w_next = r_slot + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_size_reg <= 9'd256;
            r_hash     <= HASH_BASIS;
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_occ      <= '0;
            r_ovld     <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == 2'd0) begin
                r_size_reg <= pwdata[8:0];
            end
            if (w_load) begin
                r_ovld      <= 1'b1;
                r_out_st    <= r_ost;
                r_out_stamp <= r_ostamp;
                r_out_idx   <= r_oidx;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_byte <= i_key_byte;
                        r_last <= i_key_last;
                        r_func <= i_func;
                        r_stamp <= i_stamp_in;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_hash <= w_prod ^ {56'd0, r_byte};
                    if (r_len[KW]) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_len <= r_len + LW'(1);
                    end
                    r_state <= r_last ? S_MOD : S_IDLE;
                end
                S_MOD: begin
                    if (w_mdone) begin
                        r_slot <= w_rem[SW-1:0];
                        r_cnt  <= '0;
                        r_ostamp <= '0;
                        r_oidx <= '0;
                        if (r_ovf) begin
                            r_ost <= (r_func == FUNC_INSERT[0]) ? ST_BAD_LEN : ST_NOT_FOUND;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_bi <= '0;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (!r_occ[r_slot]) begin
                        if (r_func == FUNC_INSERT[0]) begin
                            r_bi <= '0;
                            r_state <= S_WR;
                        end else begin
                            r_ost <= ST_NOT_FOUND;
                            r_state <= S_OUT;
                        end
                    end else if (sl_rd == r_len) begin
                        r_bi <= '0;
                        r_state <= S_CMPW;
                    end else begin
                        r_cnt <= r_cnt + 17'd1;
                        r_slot <= w_next;
                        r_state <= S_RD;
                        if (r_cnt + 17'd1 >= w_size) begin
                            r_ost <= (r_func == FUNC_INSERT[0]) ? ST_FULL : ST_NOT_FOUND;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_CMPW: begin
                    if (r_bi == r_len) begin
                        if (r_func == FUNC_INSERT[0]) begin
                            r_state <= S_STW;
                        end else begin
                            r_ost <= ST_FOUND;
                            r_ostamp <= ss_rd;
                            r_oidx <= 8'(r_slot);
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (kb_rd == sb_rd) begin
                        r_bi <= r_bi + LW'(1);
                        r_state <= S_CMPW;
                    end else begin
                        r_cnt <= r_cnt + 17'd1;
                        r_slot <= w_next;
                        r_state <= S_RD;
                        if (r_cnt + 17'd1 >= w_size) begin
                            r_ost <= (r_func == FUNC_INSERT[0]) ? ST_FULL : ST_NOT_FOUND;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_WR: begin
                    // key buffer read data is registered, so it arrives in the cycle after its address
                    if (r_bi == r_len) begin
                        r_state <= S_STW;
                    end else begin
                        r_bi <= r_bi + LW'(1);
                    end
                end
                S_STW: begin
                    r_occ[r_slot] <= 1'b1;
                    r_ost <= ST_STORED;
                    r_oidx <= 8'(r_slot);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // waits here while the previous result is still held
                    if (w_load) begin
                        r_hash <= HASH_BASIS;
                        r_len <= '0;
                        r_ovf <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ovld;
    assign o_status     = r_out_st;
    assign o_stamp_out  = r_out_stamp;
    assign o_slot_index = r_out_idx;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && i_stall) |=> (r_ovld && $stable(r_out_st) && $stable(r_out_stamp) &&
        $stable(r_out_idx))) else $error("result lost");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_KEY_BYTES)) else $error("length overrun");
endmodule
